FILE: design/ir_remote_sleep_timer_macros.svh
// Assertion macros used by the sleep timer top level.
// No dependencies; include by bare file name.
`ifndef IR_REMOTE_SLEEP_TIMER_MACROS_SVH
`define IR_REMOTE_SLEEP_TIMER_MACROS_SVH

// Same-cycle implication, disabled during reset.
`define IRST_ASSERT_NOW(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("sleep timer: same-cycle check failed");

// Next-cycle implication, disabled during reset.
`define IRST_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("sleep timer: next-cycle check failed");

`endif

FILE: design/irst_pkg.sv
// Shared types, constants and functions for the IR remote sleep timer.
// No dependencies.
package irst_pkg;

   localparam int FRAME_BITS    = 32;
   localparam int PHASE_TIMEOUT = 255;
   localparam int CODE_W        = 32;
   localparam int TICKS_W       = 19;
   localparam int TPM_W         = 12;
   localparam int UNIT_W        = 8;
   localparam int BIDX_W        = 6;
   localparam int BTN_W         = 3;
   localparam int CSR_IDX_W     = 3;
   localparam int CSR_DATA_W    = 32;

   // Register indexes on the CSR port
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_RED      = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_GREEN    = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_YELLOW   = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_CODE_BLUE     = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_TICKS_PER_MIN = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_LOW_MIN  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_LEAD_HIGH_MIN = 3'd6;
   localparam logic [CSR_IDX_W-1:0] CSR_ONE_THRESHOLD = 3'd7;

   // Reset values
   localparam logic [TPM_W-1:0]  TPM_RESET       = 12'd1200;
   localparam logic [UNIT_W-1:0] LEAD_LOW_RESET  = 8'h1E;
   localparam logic [UNIT_W-1:0] LEAD_HIGH_RESET = 8'h0B;
   localparam logic [UNIT_W-1:0] ONE_THR_RESET   = 8'd4;

   // Button codes
   localparam logic [BTN_W-1:0] BTN_NONE   = 3'd0;
   localparam logic [BTN_W-1:0] BTN_RED    = 3'd1;
   localparam logic [BTN_W-1:0] BTN_GREEN  = 3'd2;
   localparam logic [BTN_W-1:0] BTN_YELLOW = 3'd3;
   localparam logic [BTN_W-1:0] BTN_BLUE   = 3'd4;

   localparam logic [2:0] NEAR_END_MINUTES = 3'd5;

   typedef enum logic [4:0] {
      PH_IDLE      = 5'b00001,
      PH_LEAD_LOW  = 5'b00010,
      PH_LEAD_HIGH = 5'b00100,
      PH_BIT_LOW   = 5'b01000,
      PH_BIT_HIGH  = 5'b10000
   } irst_phase_type;

   typedef struct packed {
      logic [CODE_W-1:0] code_red;
      logic [CODE_W-1:0] code_green;
      logic [CODE_W-1:0] code_yellow;
      logic [CODE_W-1:0] code_blue;
      logic [TPM_W-1:0]  ticks_per_minute;
      logic [UNIT_W-1:0] lead_low_min;
      logic [UNIT_W-1:0] lead_high_min;
      logic [UNIT_W-1:0] one_threshold;
   } irst_cfg_type;

   // One classified request handed from the receiver to the timer
   typedef struct packed {
      logic              tick;
      logic              done;
      logic [CODE_W-1:0] code;
      logic [BTN_W-1:0]  btn;
   } irst_event_type;

   function automatic logic [7:0] minutes_for_button(input logic [BTN_W-1:0] btn);
      logic [7:0] m;
      unique case (btn)
         BTN_RED:    m = 8'd30;
         BTN_GREEN:  m = 8'd60;
         BTN_YELLOW: m = 8'd90;
         BTN_BLUE:   m = 8'd120;
         default:    m = 8'd0;
      endcase
      return m;
   endfunction

endpackage

FILE: design/irst_front.sv
// Receiver front end: measures pin phases, assembles frames, matches buttons.
// Depends on irst_pkg.
module irst_front import irst_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           accept,
   input  logic           ir_level,
   input  logic           period_tick,
   input  irst_cfg_type   cfg,
   output irst_event_type ev
);

   irst_phase_type    phase_ff, phase_in;
   logic [UNIT_W-1:0] count_ff, count_in;
   logic [BIDX_W-1:0] bidx_ff, bidx_in;
   logic [CODE_W-1:0] word_ff, word_in;

   logic              want;
   logic              same;
   logic [UNIT_W-1:0] cnt_up;
   logic [UNIT_W-1:0] cnt;
   logic              ended;
   logic [UNIT_W-1:0] carry;
   logic [CODE_W-1:0] word_shift;
   logic [BIDX_W-1:0] bidx_next;

   always_comb begin
      want       = (phase_ff == PH_LEAD_HIGH) || (phase_ff == PH_BIT_HIGH);
      same       = (ir_level == want);
      cnt_up     = (count_ff < UNIT_W'(PHASE_TIMEOUT)) ? count_ff + 1'b1 : count_ff;
      cnt        = same ? cnt_up : count_ff;
      ended      = !same || (cnt_up >= UNIT_W'(PHASE_TIMEOUT));
      carry      = {{(UNIT_W-1){1'b0}}, !same};
      word_shift = {word_ff[CODE_W-2:0], (cnt > cfg.one_threshold)};
      bidx_next  = bidx_ff + 1'b1;
   end

   always_comb begin
      phase_in = phase_ff;
      count_in = count_ff;
      bidx_in  = bidx_ff;
      word_in  = word_ff;
      ev       = '0;
      ev.tick  = period_tick;
      if (accept) begin
         unique case (phase_ff)
            PH_IDLE: begin
               if (!ir_level) begin
                  phase_in = PH_LEAD_LOW;
                  count_in = UNIT_W'(1);
               end
            end
            PH_LEAD_LOW, PH_LEAD_HIGH, PH_BIT_LOW, PH_BIT_HIGH: begin
               count_in = cnt;
               if (ended) begin
                  unique case (phase_ff)
                     PH_LEAD_LOW: begin
                        if (cnt < cfg.lead_low_min) begin
                           phase_in = PH_IDLE;
                           count_in = '0;
                        end else begin
                           phase_in = PH_LEAD_HIGH;
                           count_in = carry;
                        end
                     end
                     PH_LEAD_HIGH: begin
                        if (cnt < cfg.lead_high_min) begin
                           phase_in = PH_IDLE;
                           count_in = '0;
                        end else begin
                           word_in  = '0;
                           bidx_in  = '0;
                           phase_in = PH_BIT_LOW;
                           count_in = carry;
                        end
                     end
                     PH_BIT_LOW: begin
                        phase_in = PH_BIT_HIGH;
                        count_in = carry;
                     end
                     default: begin
                        // bit high phase ended: shift in the bit
                        word_in = word_shift;
                        if (bidx_next >= BIDX_W'(FRAME_BITS)) begin
                           ev.done  = 1'b1;
                           ev.code  = word_shift;
                           bidx_in  = '0;
                           phase_in = PH_IDLE;
                           count_in = '0;
                        end else begin
                           bidx_in  = bidx_next;
                           phase_in = PH_BIT_LOW;
                           count_in = carry;
                        end
                     end
                  endcase
               end
            end
            default: begin
               phase_in = PH_IDLE;
               count_in = '0;
            end
         endcase
      end
      // lowest button number wins on equal codes
      if (ev.done) begin
         priority if (ev.code == cfg.code_red)    ev.btn = BTN_RED;
         else if     (ev.code == cfg.code_green)  ev.btn = BTN_GREEN;
         else if     (ev.code == cfg.code_yellow) ev.btn = BTN_YELLOW;
         else if     (ev.code == cfg.code_blue)   ev.btn = BTN_BLUE;
         else                                     ev.btn = BTN_NONE;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         phase_ff <= PH_IDLE;
         count_ff <= '0;
         bidx_ff  <= '0;
         word_ff  <= '0;
      end else begin
         phase_ff <= phase_in;
         count_ff <= count_in;
         bidx_ff  <= bidx_in;
         word_ff  <= word_in;
      end
   end

endmodule

FILE: design/irst_fifo.sv
// Two-entry queue of classified requests between receiver and timer.
// Depends on irst_pkg.
module irst_fifo import irst_pkg::*; (
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  irst_event_type push_data,
   input  logic           pop,
   output irst_event_type pop_data,
   output logic           not_empty,
   output logic           full,
   output logic [1:0]     level
);

   irst_event_type entry_ff [2];
   logic           wr_ptr_ff, wr_ptr_in;
   logic           rd_ptr_ff, rd_ptr_in;
   logic [1:0]     count_ff, count_in;
   logic           do_push, do_pop;

   always_comb begin
      do_push   = push && (count_ff != 2'd2);
      do_pop    = pop && (count_ff != 2'd0);
      wr_ptr_in = wr_ptr_ff ^ do_push;
      rd_ptr_in = rd_ptr_ff ^ do_pop;
      count_in  = count_ff + {1'b0, do_push} - {1'b0, do_pop};
      pop_data  = entry_ff[rd_ptr_ff];
      not_empty = (count_ff != 2'd0);
      full      = (count_ff == 2'd2);
      level     = count_ff;
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= 2'd0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/irst_back.sv
// Timer back end: countdown, relay, near-end flag and the response register.
// Depends on irst_pkg.
module irst_back import irst_pkg::*; (
   input  logic              clock,
   input  logic              reset,
   input  logic              ev_valid,
   input  irst_event_type    ev,
   input  logic [TPM_W-1:0]  ticks_per_minute,
   output logic              ev_pop,
   output logic              rsp_valid,
   input  logic              rsp_stall,
   output logic              rsp_power_on,
   output logic              rsp_frame_done,
   output logic [CODE_W-1:0] rsp_frame_code,
   output logic [BTN_W-1:0]  rsp_matched_button,
   output logic              rsp_near_end
);

   logic [TICKS_W-1:0] remain_ff, remain_in;
   logic               relay_ff, relay_in;
   logic               valid_ff, valid_in;
   logic               power_ff, done_ff, near_ff;
   logic [CODE_W-1:0]  code_ff;
   logic [BTN_W-1:0]   btn_ff;

   logic [TICKS_W-1:0] after_tick;
   logic [TPM_W+7:0]   load_full;
   logic [TPM_W+2:0]   five_min;
   logic               near;

   always_comb begin
      ev_pop   = ev_valid && (!valid_ff || !rsp_stall);
      relay_in = relay_ff;
      after_tick = remain_ff;
      if (ev.tick && (remain_ff != '0)) begin
         after_tick = remain_ff - 1'b1;
         relay_in   = (after_tick != '0);
      end
      load_full = minutes_for_button(ev.btn) * ticks_per_minute;
      remain_in = after_tick;
      if (ev.done && (ev.btn != BTN_NONE)) begin
         remain_in = load_full[TICKS_W-1:0];
      end
      five_min = TPM_W'(0) + ticks_per_minute * NEAR_END_MINUTES;
      near     = (remain_in != '0) && (remain_in < TICKS_W'(five_min));
      valid_in = ev_pop ? 1'b1 : (valid_ff && rsp_stall);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         remain_ff <= '0;
         relay_ff  <= 1'b0;
         valid_ff  <= 1'b0;
      end else begin
         valid_ff <= valid_in;
         if (ev_pop) begin
            remain_ff <= remain_in;
            relay_ff  <= relay_in;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (ev_pop) begin
         power_ff <= relay_in;
         done_ff  <= ev.done;
         code_ff  <= ev.code;
         btn_ff   <= ev.btn;
         near_ff  <= near;
      end
   end

   assign rsp_valid          = valid_ff;
   assign rsp_power_on       = power_ff;
   assign rsp_frame_done     = done_ff;
   assign rsp_frame_code     = code_ff;
   assign rsp_matched_button = btn_ff;
   assign rsp_near_end       = near_ff;

endmodule

FILE: design/ir_remote_sleep_timer.sv
// IR remote sleep timer: top level with CSR bank, receiver, queue and timer.
// Depends on irst_pkg, irst_front, irst_fifo, irst_back and the macros header.
//
// Usage:
//  - Request channel (req_valid/req_stall): one pin sample per 256 us unit
//    (req_ir_level, 0 = carrier) plus req_period_tick, high once per 50 ms.
//  - Response channel (rsp_valid/rsp_stall): one response per request with
//    relay drive, frame completion, received code, matched button and the
//    last-five-minutes flag.
//  - CSR port: write csr_wdata to register csr_index while csr_we is high;
//    write only while no request is in flight.
//  - Throughput: one request per cycle unless stalled. The receiver handles a
//    sample in the cycle it is accepted; the timer reads a two-entry queue.
//  - Path: an accepted request is written into the queue, then into the
//    response register behind rsp_valid once the response side is not stalled.
//  - Stall: a stalled response holds in its output register; the queue fills
//    behind it and req_stall rises once both entries are occupied.
//  - Reset: receiver idle, countdown stopped, relay off, CSRs at defaults
//    (codes 0, 1200 ticks per minute, leader minimums 30 and 11, threshold 4).
`include "ir_remote_sleep_timer_macros.svh"

module ir_remote_sleep_timer import irst_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   // request channel
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic                  req_ir_level,
   input  logic                  req_period_tick,
   // response channel
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic                  rsp_power_on,
   output logic                  rsp_frame_done,
   output logic [CODE_W-1:0]     rsp_frame_code,
   output logic [BTN_W-1:0]      rsp_matched_button,
   output logic                  rsp_near_end,
   // configuration
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   irst_cfg_type   cfg_ff;
   irst_event_type ev_front;
   irst_event_type ev_queue;
   logic           req_accept;
   logic           q_not_empty;
   logic           q_full;
   logic [1:0]     q_level;
   logic           ev_pop;

   // CSR bank: hold settings, update on write
   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.code_red         <= '0;
         cfg_ff.code_green       <= '0;
         cfg_ff.code_yellow      <= '0;
         cfg_ff.code_blue        <= '0;
         cfg_ff.ticks_per_minute <= TPM_RESET;
         cfg_ff.lead_low_min     <= LEAD_LOW_RESET;
         cfg_ff.lead_high_min    <= LEAD_HIGH_RESET;
         cfg_ff.one_threshold    <= ONE_THR_RESET;
      end else if (csr_we) begin
         unique case (csr_index)
            CSR_CODE_RED:      cfg_ff.code_red         <= csr_wdata;
            CSR_CODE_GREEN:    cfg_ff.code_green       <= csr_wdata;
            CSR_CODE_YELLOW:   cfg_ff.code_yellow      <= csr_wdata;
            CSR_CODE_BLUE:     cfg_ff.code_blue        <= csr_wdata;
            CSR_TICKS_PER_MIN: cfg_ff.ticks_per_minute <= csr_wdata[TPM_W-1:0];
            CSR_LEAD_LOW_MIN:  cfg_ff.lead_low_min     <= csr_wdata[UNIT_W-1:0];
            CSR_LEAD_HIGH_MIN: cfg_ff.lead_high_min    <= csr_wdata[UNIT_W-1:0];
            CSR_ONE_THRESHOLD: cfg_ff.one_threshold    <= csr_wdata[UNIT_W-1:0];
            default:           cfg_ff.one_threshold    <= cfg_ff.one_threshold;
         endcase
      end
   end

   // Stall requests only when the queue has no room
   assign req_stall  = q_full;
   assign req_accept = req_valid && !req_stall;

   irst_front u_front (
      .clock       (clock),
      .reset       (reset),
      .accept      (req_accept),
      .ir_level    (req_ir_level),
      .period_tick (req_period_tick),
      .cfg         (cfg_ff),
      .ev          (ev_front)
   );

   irst_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (req_accept),
      .push_data (ev_front),
      .pop       (ev_pop),
      .pop_data  (ev_queue),
      .not_empty (q_not_empty),
      .full      (q_full),
      .level     (q_level)
   );

   irst_back u_back (
      .clock              (clock),
      .reset              (reset),
      .ev_valid           (q_not_empty),
      .ev                 (ev_queue),
      .ticks_per_minute   (cfg_ff.ticks_per_minute),
      .ev_pop             (ev_pop),
      .rsp_valid          (rsp_valid),
      .rsp_stall          (rsp_stall),
      .rsp_power_on       (rsp_power_on),
      .rsp_frame_done     (rsp_frame_done),
      .rsp_frame_code     (rsp_frame_code),
      .rsp_matched_button (rsp_matched_button),
      .rsp_near_end       (rsp_near_end)
   );

   // A response without a completed frame carries no code and no button
   `IRST_ASSERT_NOW(a_idle_code_zero, clock, reset, rsp_valid && !rsp_frame_done, (rsp_frame_code == '0) && (rsp_matched_button == BTN_NONE))
   // A matched button implies a completed frame
   `IRST_ASSERT_NOW(a_button_needs_frame, clock, reset, rsp_valid && (rsp_matched_button != BTN_NONE), rsp_frame_done)
   // An accepted request is queued on the next cycle
   `IRST_ASSERT_NEXT(a_accept_queued, clock, reset, req_accept, q_level != 2'd0)

endmodule
